@@ sv/bbnr_pkg.sv @@
package bbnr_pkg;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_REL   = 2'd2;
    localparam logic [1:0] REQ_FIND  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_ENTRY  = 2'd1;
    localparam logic [1:0] ST_NO_VICTIM = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_REL,
        S_FIND,
        S_FREE,
        S_PA,
        S_PB,
        S_PC,
        S_PD,
        S_EVICT,
        S_MARK
    } state_t;

endpackage

@@ sv/bbnr_cell.sv @@
module bbnr_cell
#(
    parameter int W = 1
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         shift,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] data_reg;
    logic [W-1:0] data_next;

    always_comb
    begin
        data_next = shift ? d : data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign q = data_reg;

endmodule

@@ sv/block_bitmap_alloc_nru_replace_core.sv @@
// channel   | ports                                              | direction
// ----------+----------------------------------------------------+----------
// request   | start, busy, req_type, entry_*, block_index         | in, busy out
// result    | done, status, out_block, out_entry, evicted,        | out
//           | victim_entry                                        |
// config    | cfg_wr_en, cfg_wr_data                              | in
//
// Entries and blocks sit in two rings of cells; a ring rotates one place a cycle
// while a pass on it runs, and each sequencer pass is one full turn of a ring:
// an entry turn for load and find, a block turn for release and for allocating
// a free block. A full bitmap adds 2 to 4 entry turns per search round (one
// turn when no entry owns a block), then one entry turn and one block turn to
// evict. Reset clears both rings and the sequencer; results cannot be stalled.
module block_bitmap_alloc_nru_replace_core
    import bbnr_pkg::*;
#(
    parameter int ENTRIES  = 64,
    parameter int BLOCKS   = 64,
    parameter int KEY_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [5:0]  entry_index,
    input  logic        entry_valid,
    input  logic [31:0] entry_key,
    input  logic        entry_accessed,
    input  logic        entry_modified,
    input  logic        entry_has_block,
    input  logic [5:0]  block_index,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    output logic        done,
    output logic [1:0]  status,
    output logic [5:0]  out_block,
    output logic [5:0]  out_entry,
    output logic        evicted,
    output logic [5:0]  victim_entry
);

    localparam int EW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int BW  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CW  = (EW > BW) ? EW : BW;
    localparam int XW  = ((CW > 6) ? CW : 6) + 1;
    localparam int RW  = $clog2(2 * ENTRIES + 3);
    localparam int DW  = KEY_BITS + 10;
    localparam int KP  = 9;

    state_t state_reg, state_next;

    logic [DW-1:0]       ring_q [ENTRIES];
    logic [BLOCKS-1:0]   bring_q;
    logic [DW-1:0]       tail;
    logic                b_tail;
    logic                e_shift, b_shift;

    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [XW-1:0]       cnt_x;
    logic [RW-1:0]       round_reg, round_next;
    logic                found_reg, found_next;
    logic                any_reg, any_next;
    logic [XW-1:0]       fidx_reg, fidx_next;
    logic [KEY_BITS-1:0] fkey_reg, fkey_next;
    logic [5:0]          fblk_reg, fblk_next;
    logic                fa_reg, fa_next, fm_reg, fm_next;
    logic                ga_reg, ga_next, gm_reg, gm_next;
    logic [6:0]          cfg_reg;
    logic [5:0]          ld_idx_reg, ld_idx_next, ld_blk_reg, ld_blk_next;
    logic                ld_v_reg, ld_v_next, ld_a_reg, ld_a_next;
    logic                ld_m_reg, ld_m_next, ld_o_reg, ld_o_next;
    logic [KEY_BITS-1:0] ld_key_reg, ld_key_next;
    logic                done_reg, done_next;
    logic [1:0]          status_reg, status_next;
    logic [5:0]          ob_reg, ob_next, oe_reg, oe_next, ve_reg, ve_next;
    logic                ev_reg, ev_next;

    logic                hv, ha, hm, ho, bh;
    logic [KEY_BITS-1:0] hkey;
    logic [5:0]          hblk;
    logic [63:0]         key_x;
    logic                accept, last, cand, grp, lim;
    logic                free_hit, pa_hit, pb_hit, find_hit;
    logic                ga_new, gm_new;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign cnt_x  = XW'(cnt_reg);
    assign key_x  = {32'd0, entry_key};

    assign hv   = ring_q[0][DW-1];
    assign hkey = ring_q[0][KP +: KEY_BITS];
    assign ha   = ring_q[0][8];
    assign hm   = ring_q[0][7];
    assign ho   = ring_q[0][6];
    assign hblk = ring_q[0][5:0];
    assign bh   = bring_q[0];

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_ent
            bbnr_cell #(.W(DW)) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (e_shift),
                .d     ((g == ENTRIES - 1) ? tail : ring_q[(g + 1) % ENTRIES]),
                .q     (ring_q[g])
            );
        end
        for (g = 0; g < BLOCKS; g++)
        begin : g_blk
            bbnr_cell #(.W(1)) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (b_shift),
                .d     ((g == BLOCKS - 1) ? b_tail : bring_q[(g + 1) % BLOCKS]),
                .q     (bring_q[g])
            );
        end
    endgenerate

    always_comb
    begin
        b_shift = (state_reg == S_FREE) || (state_reg == S_REL) || (state_reg == S_MARK);
        e_shift = busy && !b_shift;
        last    = b_shift ? (cnt_x == XW'(BLOCKS - 1)) : (cnt_x == XW'(ENTRIES - 1));
        cand    = hv && ho;
        grp     = cand && (hkey == fkey_reg) && (hblk == fblk_reg);
        free_hit = !found_reg && !bh && (cnt_x < XW'(cfg_reg)) && (cnt_x < XW'(64));
        pa_hit  = !found_reg && cand && !ha && !hm;
        pb_hit  = !found_reg && cand && !ha;
        find_hit = !found_reg && !hv;
        ga_new  = ga_reg | (grp & ha);
        gm_new  = gm_reg | (grp & hm);
        lim     = (round_reg == RW'(2 * ENTRIES + 1));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_LOAD:  state_next = S_LOAD;
                        REQ_ALLOC: state_next = S_FREE;
                        REQ_REL:   state_next = S_REL;
                        default:   state_next = S_FIND;
                    endcase
                end
            end
            S_LOAD, S_REL, S_FIND, S_MARK:
            begin
                if (last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FREE:
            begin
                if (last)
                begin
                    state_next = (found_reg || free_hit) ? S_IDLE : S_PA;
                end
            end
            S_PA:
            begin
                if (last)
                begin
                    if (found_reg || pa_hit)
                        state_next = S_PC;
                    else
                        state_next = (any_reg || cand) ? S_PB : S_IDLE;
                end
            end
            S_PB:
            begin
                if (last)
                begin
                    if (found_reg || pb_hit)
                        state_next = S_PC;
                    else
                        state_next = lim ? S_IDLE : S_PA;
                end
            end
            S_PC:
            begin
                if (last)
                begin
                    state_next = (ga_new == fa_reg && gm_new == fm_reg) ? S_EVICT : S_PD;
                end
            end
            S_PD:
            begin
                if (last)
                begin
                    state_next = lim ? S_EVICT : S_PA;
                end
            end
            S_EVICT:
            begin
                if (last)
                begin
                    state_next = S_MARK;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        logic tv, ta, tm, to;
        logic [KEY_BITS-1:0] tk;
        logic [5:0] tb;
        tv = hv; tk = hkey; ta = ha; tm = hm; to = ho; tb = hblk;
        b_tail = bh;
        cnt_next = (busy && !last) ? cnt_reg + CW'(1) : '0;
        round_next = round_reg; found_next = found_reg; any_next = any_reg;
        fidx_next = fidx_reg; fkey_next = fkey_reg; fblk_next = fblk_reg;
        fa_next = fa_reg; fm_next = fm_reg; ga_next = ga_reg; gm_next = gm_reg;
        ld_idx_next = ld_idx_reg; ld_blk_next = ld_blk_reg;
        ld_v_next = ld_v_reg; ld_a_next = ld_a_reg; ld_m_next = ld_m_reg;
        ld_o_next = ld_o_reg; ld_key_next = ld_key_reg;
        done_next = 1'b0; status_next = status_reg; ob_next = ob_reg;
        oe_next = oe_reg; ev_next = ev_reg; ve_next = ve_reg;
        if (last)
        begin
            status_next = ST_OK; ob_next = '0; oe_next = '0; ev_next = 1'b0; ve_next = '0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ld_idx_next = entry_index; ld_blk_next = block_index;
                    ld_v_next = entry_valid; ld_a_next = entry_accessed;
                    ld_m_next = entry_modified; ld_o_next = entry_has_block;
                    ld_key_next = key_x[KEY_BITS-1:0];
                    found_next = 1'b0; any_next = 1'b0; round_next = '0;
                end
            end
            S_LOAD:
            begin
                if (cnt_x == XW'(ld_idx_reg))
                begin
                    tv = ld_v_reg; tk = ld_key_reg; ta = ld_a_reg;
                    tm = ld_m_reg; to = ld_o_reg; tb = ld_blk_reg;
                end
                done_next = last;
            end
            S_REL:
            begin
                if (cnt_x == XW'(ld_blk_reg))
                    b_tail = 1'b0;
                done_next = last;
            end
            S_FIND:
            begin
                if (find_hit)
                begin
                    found_next = 1'b1; fidx_next = cnt_x;
                end
                if (last)
                begin
                    done_next = 1'b1;
                    status_next = (found_reg || find_hit) ? ST_OK : ST_NO_ENTRY;
                    oe_next = find_hit ? cnt_x[5:0] : (found_reg ? fidx_reg[5:0] : 6'd0);
                end
            end
            S_FREE:
            begin
                if (free_hit)
                begin
                    b_tail = 1'b1; found_next = 1'b1; fblk_next = cnt_x[5:0];
                end
                if (last)
                begin
                    if (found_reg || free_hit)
                    begin
                        done_next = 1'b1;
                        ob_next = free_hit ? cnt_x[5:0] : fblk_reg;
                    end
                    else
                    begin
                        found_next = 1'b0;
                    end
                end
            end
            S_PA:
            begin
                any_next = any_reg | cand;
                if (pa_hit)
                begin
                    found_next = 1'b1; fidx_next = cnt_x; fkey_next = hkey;
                    fblk_next = hblk; fa_next = 1'b0; fm_next = 1'b0;
                end
                if (last)
                begin
                    ga_next = 1'b0; gm_next = 1'b0;
                    if (!found_reg && !pa_hit && !any_reg && !cand)
                    begin
                        done_next = 1'b1; status_next = ST_NO_VICTIM;
                    end
                end
            end
            S_PB:
            begin
                if (pb_hit)
                begin
                    found_next = 1'b1; fidx_next = cnt_x; fkey_next = hkey;
                    fblk_next = hblk; fa_next = 1'b0; fm_next = hm;
                end
                else if (!found_reg && hv)
                begin
                    ta = 1'b0;
                end
                if (last)
                begin
                    ga_next = 1'b0; gm_next = 1'b0;
                    if (!found_reg && !pb_hit)
                    begin
                        if (lim)
                        begin
                            done_next = 1'b1; status_next = ST_NO_VICTIM;
                        end
                        else
                        begin
                            round_next = round_reg + RW'(1);
                        end
                    end
                end
            end
            S_PC:
            begin
                ga_next = ga_new; gm_next = gm_new;
            end
            S_PD:
            begin
                if (grp)
                begin
                    ta = ga_reg; tm = gm_reg;
                end
                if (last && !lim)
                begin
                    round_next = round_reg + RW'(1); found_next = 1'b0;
                end
            end
            S_EVICT:
            begin
                if (cnt_x == fidx_reg)
                begin
                    to = 1'b0; tb = '0;
                end
            end
            S_MARK:
            begin
                if (cnt_x == XW'(fblk_reg))
                    b_tail = 1'b1;
                if (last)
                begin
                    done_next = 1'b1; ob_next = fblk_reg; ev_next = 1'b1;
                    ve_next = fidx_reg[5:0];
                end
            end
            default:
            begin
                found_next = 1'b0;
            end
        endcase
        tail = {tv, tk, ta, tm, to, tb};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            round_reg <= '0;
            found_reg <= 1'b0;
            any_reg   <= 1'b0;
            done_reg  <= 1'b0;
            cfg_reg   <= 7'd64;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            round_reg <= round_next;
            found_reg <= found_next;
            any_reg   <= any_next;
            done_reg  <= done_next;
            if (cfg_wr_en)
                cfg_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        fidx_reg <= fidx_next; fkey_reg <= fkey_next; fblk_reg <= fblk_next;
        fa_reg <= fa_next; fm_reg <= fm_next; ga_reg <= ga_next; gm_reg <= gm_next;
        ld_idx_reg <= ld_idx_next; ld_blk_reg <= ld_blk_next;
        ld_v_reg <= ld_v_next; ld_a_reg <= ld_a_next; ld_m_reg <= ld_m_next;
        ld_o_reg <= ld_o_next; ld_key_reg <= ld_key_next;
        status_reg <= status_next; ob_reg <= ob_next; oe_reg <= oe_next;
        ev_reg <= ev_next; ve_reg <= ve_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign out_block    = ob_reg;
    assign out_entry    = oe_reg;
    assign evicted      = ev_reg;
    assign victim_entry = ve_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result strobe outside idle");
    a_evict_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && ev_reg) |-> status_reg == ST_OK)
        else $error("eviction with error status");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted transaction did not start");
    a_pd_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PD || state_reg == S_EVICT) |-> found_reg)
        else $error("group update without a victim");

endmodule
